@@ sv/lps_pkg.sv @@
package lps_pkg;

  localparam int unsigned CompW    = 16;
  localparam int unsigned DivSteps = 32;
  localparam int unsigned SqrSteps = 17;
  localparam int unsigned RadW     = 2 * SqrSteps;
  localparam int unsigned RootW    = SqrSteps;
  localparam int unsigned SqRemW   = RootW + 3;

  localparam logic [22:0] TintBase = 23'd2293760;
  localparam logic [6:0]  TintMul  = 7'd65;
  localparam logic [18:0] ShadeOne = 19'd262144;
  localparam logic [23:0] Recip100 = 24'd10737419;
  localparam logic [16:0] CosOne   = 17'd65536;
  localparam logic [15:0] ChanMax  = 16'hffff;

  typedef struct packed {
    logic [CompW-1:0] base_red;
    logic [CompW-1:0] base_green;
    logic [CompW-1:0] base_blue;
    logic [CompW-1:0] rough_amount;
    logic [CompW-1:0] metal_amount;
    logic             degenerate;
    logic             facing;
  } lps_side_t;

  typedef struct packed {
    logic [63:0]          rem;
    logic [63:0]          den;
    logic [DivSteps-1:0]  quo;
    logic                 full;
    lps_side_t            side;
  } lps_div_t;

  typedef struct packed {
    logic [RadW-1:0]   rad;
    logic [SqRemW-1:0] rem;
    logic [RootW-1:0]  root;
    lps_side_t         side;
  } lps_sqr_t;

endpackage

@@ sv/lambert_preview_shader.sv @@
// lambert preview shader: diffuse shading of one pixel per transfer
// input channel in_*: one transfer carries both vectors and the material
// output channel out_*: shaded colour in tdata, degenerate flag in tuser
// from input transfer to output valid an item passes 4 front stages,
// a chain of 32 divider cells (one quotient bit each), a chain of 17 square
// root cells (one root bit each), 4 multiply stages and the output register
// throughput is one item per cycle while out_tready stays high
// the whole pipeline advances together; when the receiver stalls with a
// result waiting, in_tready drops in the same cycle and every stage holds
// synchronous reset clears all stage valid bits; no state survives an item
// a zero length vector gives black with the degenerate flag set, a light
// behind the surface gives black with the flag clear
module lambert_preview_shader (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // normal_x, normal_y, normal_z, light_x, light_y, light_z,
  // base_red, base_green, base_blue, rough_amount, metal_amount
  input  logic [175:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // shaded_red, shaded_green, shaded_blue
  output logic [47:0]  out_tdata,
  // degenerate
  output logic [0:0]   out_tuser
);
  import lps_pkg::*;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  logic signed [15:0] nx, ny, nz, lx, ly, lz;
  lps_side_t          side_in;
  assign nx = in_tdata[15:0];
  assign ny = in_tdata[31:16];
  assign nz = in_tdata[47:32];
  assign lx = in_tdata[63:48];
  assign ly = in_tdata[79:64];
  assign lz = in_tdata[95:80];
  always_comb begin
    side_in.base_red     = in_tdata[111:96];
    side_in.base_green   = in_tdata[127:112];
    side_in.base_blue    = in_tdata[143:128];
    side_in.rough_amount = in_tdata[159:144];
    side_in.metal_amount = in_tdata[175:160];
    side_in.degenerate   = 1'b0;
    side_in.facing       = 1'b0;
  end

  // stage 0: squares and component products
  logic               v0_r;
  logic        [31:0] sqn_r [3];
  logic        [31:0] sql_r [3];
  logic signed [31:0] dp_r  [3];
  lps_side_t          s0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sqn_r[0] <= 32'(nx * nx);
      sqn_r[1] <= 32'(ny * ny);
      sqn_r[2] <= 32'(nz * nz);
      sql_r[0] <= 32'(lx * lx);
      sql_r[1] <= 32'(ly * ly);
      sql_r[2] <= 32'(lz * lz);
      dp_r[0]  <= 32'(nx * lx);
      dp_r[1]  <= 32'(ny * ly);
      dp_r[2]  <= 32'(nz * lz);
      s0_r     <= side_in;
    end
  end

  // stage 1: squared lengths and dot product
  logic               v1_r;
  logic        [31:0] nn_r, ll_r;
  logic signed [33:0] dot_r;
  lps_side_t          s1_r;
  lps_side_t          s1_nxt;
  logic        [31:0] nn_nxt, ll_nxt;

  always_comb begin
    nn_nxt = sqn_r[0] + sqn_r[1] + sqn_r[2];
    ll_nxt = sql_r[0] + sql_r[1] + sql_r[2];
    s1_nxt = s0_r;
    s1_nxt.degenerate = (nn_nxt == 32'd0) || (ll_nxt == 32'd0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nn_r  <= nn_nxt;
      ll_r  <= ll_nxt;
      dot_r <= 34'(dp_r[0]) + 34'(dp_r[1]) + 34'(dp_r[2]);
      s1_r  <= s1_nxt;
    end
  end

  // stage 2: product of squared lengths and square of dot product
  logic        v2_r;
  logic [63:0] prod_r, dsq_r;
  lps_side_t   s2_r;
  lps_side_t   s2_nxt;
  logic [31:0] ud;

  always_comb begin
    s2_nxt = s1_r;
    s2_nxt.facing = (dot_r > 34'sd0) && !s1_r.degenerate;
    ud = s2_nxt.facing ? dot_r[31:0] : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= 64'(nn_r) * 64'(ll_r);
      dsq_r  <= 64'(ud) * 64'(ud);
      s2_r   <= s2_nxt;
    end
  end

  // stage 3: divider chain head
  logic     v3_r;
  lps_div_t d3_r;
  lps_div_t d3_nxt;

  always_comb begin
    d3_nxt.full = dsq_r >= prod_r;
    d3_nxt.rem  = d3_nxt.full ? 64'd0 : dsq_r;
    d3_nxt.den  = prod_r;
    d3_nxt.quo  = '0;
    d3_nxt.side = s2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d3_r <= d3_nxt;
    end
  end

  logic     dv   [DivSteps+1];
  lps_div_t dst  [DivSteps+1];
  assign dv[0]  = v3_r;
  assign dst[0] = d3_r;

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    lps_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (dv[i]),
      .in_stage  (dst[i]),
      .out_valid (dv[i+1]),
      .out_stage (dst[i+1])
    );
  end

  lps_sqr_t    sq_head;
  lps_div_t    dlast;
  logic [32:0] frac;
  assign dlast = dst[DivSteps];
  assign frac  = dlast.full ? {1'b1, 32'd0} : {1'b0, dlast.quo};
  always_comb begin
    sq_head.rad  = {1'b0, frac};
    sq_head.rem  = '0;
    sq_head.root = '0;
    sq_head.side = dlast.side;
  end

  logic     sv   [SqrSteps+1];
  lps_sqr_t sst  [SqrSteps+1];
  assign sv[0]  = dv[DivSteps];
  assign sst[0] = sq_head;

  for (genvar j = 0; j < SqrSteps; j++) begin : g_sqr
    lps_sqr_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (sv[j]),
      .in_stage  (sst[j]),
      .out_valid (sv[j+1]),
      .out_stage (sst[j+1])
    );
  end

  // stage a: cosine times tint
  lps_sqr_t    slast;
  logic [16:0] cos16;
  logic [22:0] tint;
  assign slast = sst[SqrSteps];
  assign cos16 = !slast.side.facing ? 17'd0 :
                 (slast.root > CosOne) ? CosOne : slast.root;
  assign tint  = TintBase + 23'(TintMul * slast.side.metal_amount);

  logic        va_r;
  logic [39:0] pa_r;
  lps_side_t   sa_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r <= 40'(cos16) * 40'(tint);
      sa_r <= slast.side;
    end
  end

  // stage b: divide by one hundred through the reciprocal
  logic        vb_r;
  logic [46:0] pb_r;
  lps_side_t   sb_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pb_r <= 47'(pa_r[38:16]) * 47'(Recip100);
      sb_r <= sa_r;
    end
  end

  // stage c: roughness shadow
  logic        vc_r;
  logic [35:0] pc_r;
  lps_side_t   sc_r;
  logic [18:0] shade;
  assign shade = ShadeOne - 19'(sb_r.rough_amount);

  always_ff @(posedge clk) begin
    if (en) begin
      pc_r <= 36'(pb_r[46:30]) * 36'(shade);
      sc_r <= sb_r;
    end
  end

  // stage d: colour channels
  logic        vd_r;
  logic [32:0] ch_r [3];
  logic        deg_d_r;
  logic [16:0] k2;
  assign k2 = pc_r[34:18];

  always_ff @(posedge clk) begin
    if (en) begin
      ch_r[0] <= 33'(sc_r.base_red) * 33'(k2);
      ch_r[1] <= 33'(sc_r.base_green) * 33'(k2);
      ch_r[2] <= 33'(sc_r.base_blue) * 33'(k2);
      deg_d_r <= sc_r.degenerate;
    end
  end

  // stage e: saturate into the output register
  logic        ve_r;
  logic [47:0] odata_r;
  logic [47:0] odata_nxt;
  logic        odeg_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      odata_nxt[16*c +: 16] = (ch_r[c][32] != 1'b0) ? ChanMax : ch_r[c][31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      odata_r <= odata_nxt;
      odeg_r  <= deg_d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_tvalid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      va_r <= sv[SqrSteps];
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
    end
  end

  assign out_tvalid = ve_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = odeg_r;
endmodule

@@ sv/lps_div_cell.sv @@
module lps_div_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  lps_pkg::lps_div_t in_stage,
  output logic              out_valid,
  output lps_pkg::lps_div_t out_stage
);
  import lps_pkg::*;

  logic        valid_r;
  lps_div_t    stage_r;
  lps_div_t    stage_nxt;
  logic [64:0] shifted;
  logic [64:0] diff;
  logic        ge;

  always_comb begin
    shifted   = {in_stage.rem, 1'b0};
    diff      = shifted - {1'b0, in_stage.den};
    ge        = shifted >= {1'b0, in_stage.den};
    stage_nxt = in_stage;
    stage_nxt.rem = ge ? diff[63:0] : shifted[63:0];
    stage_nxt.quo = {in_stage.quo[DivSteps-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_stage = stage_r;
endmodule

@@ sv/lps_sqr_cell.sv @@
module lps_sqr_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  lps_pkg::lps_sqr_t in_stage,
  output logic              out_valid,
  output lps_pkg::lps_sqr_t out_stage
);
  import lps_pkg::*;

  logic              valid_r;
  lps_sqr_t          stage_r;
  lps_sqr_t          stage_nxt;
  logic [SqRemW-1:0] cand;
  logic [SqRemW-1:0] trial;
  logic              ge;

  always_comb begin
    cand  = {in_stage.rem[SqRemW-3:0], in_stage.rad[RadW-1:RadW-2]};
    trial = {1'b0, in_stage.root, 2'b01};
    ge    = cand >= trial;
    stage_nxt      = in_stage;
    stage_nxt.rad  = {in_stage.rad[RadW-3:0], 2'b00};
    stage_nxt.rem  = ge ? (cand - trial) : cand;
    stage_nxt.root = {in_stage.root[RootW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_stage = stage_r;
endmodule

@@ sv/lps_checker.sv @@
module lps_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [175:0] in_tdata,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [47:0]  out_tdata,
  input logic [0:0]   out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_degen_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == 48'd0)
    else $error("degenerate result not black");

  a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready not tied to output slot");

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |=> out_tvalid)
    else $error("output lost during stall");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata))
    else $error("waiting input transfer changed");

endmodule

bind lambert_preview_shader lps_checker u_lps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
